FILE: rtl/i2crm_pkg.sv
`default_nettype none

package i2crm_pkg;

  // Bus commands carried by an input item
  typedef enum logic [1:0] {
    CMD_NONE       = 2'd0,
    CMD_WRITE_BYTE = 2'd1,
    CMD_READ_BYTE  = 2'd2,
    CMD_READ_WORD  = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_DEVICE_ADDRESS  = 1'b0,
    CFG_TICKS_PER_PHASE = 1'b1
  } cfg_reg_e;

  // Line sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_TXL, ST_TXH, ST_RSA, ST_RSB, ST_RSC,
    ST_RXL, ST_RXH, ST_PA, ST_PB, ST_PC
  } step_e;

  // Transaction program tokens
  typedef enum logic [3:0] {
    TK_START, TK_TXW, TK_TXREG, TK_TXDATA, TK_RSTART, TK_TXR, TK_RX,
    TK_STOP, TK_TXREG2, TK_RX2
  } token_e;

  localparam int unsigned StageW = 4;
  typedef logic [StageW-1:0] stage_t;
  typedef logic [StageW:0]   stage_cnt_t;

  localparam logic [6:0] DEV_ADDR_RESET = 7'd104;
  localparam logic [7:0] TPP_RESET      = 8'd5;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        nack_seen;
  } out_item_t;

  // What starting a token does to the sequencer
  typedef struct packed {
    step_e      step;
    logic       load;
    logic [7:0] shift;
  } tok_start_t;

  function automatic stage_cnt_t prog_len(cmd_e c);
    stage_cnt_t n;
    case (c)
      CMD_WRITE_BYTE: n = 5'd5;
      CMD_READ_BYTE:  n = 5'd7;
      CMD_READ_WORD:  n = 5'd14;
      default:        n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic token_e cur_token(cmd_e c, stage_t s);
    token_e t;
    t = TK_STOP;
    if ({1'b0, s} < prog_len(c)) begin
      case (s)
        4'd0:    t = TK_START;
        4'd1:    t = TK_TXW;
        4'd2:    t = TK_TXREG;
        4'd3:    t = (c == CMD_WRITE_BYTE) ? TK_TXDATA : TK_RSTART;
        4'd4:    t = (c == CMD_WRITE_BYTE) ? TK_STOP : TK_TXR;
        4'd5:    t = TK_RX;
        4'd7:    t = TK_START;
        4'd8:    t = TK_TXW;
        4'd9:    t = TK_TXREG2;
        4'd10:   t = TK_RSTART;
        4'd11:   t = TK_TXR;
        4'd12:   t = TK_RX2;
        default: t = TK_STOP;
      endcase
    end
    return t;
  endfunction

  function automatic tok_start_t tok_begin(token_e t, logic [6:0] dev,
                                           logic [7:0] reg_addr, logic [7:0] wbyte);
    tok_start_t r;
    r.load  = 1'b0;
    r.shift = 8'h00;
    case (t)
      TK_START:  r.step = ST_START;
      TK_TXW: begin
        r.step = ST_TXL; r.load = 1'b1; r.shift = {dev, 1'b0};
      end
      TK_TXR: begin
        r.step = ST_TXL; r.load = 1'b1; r.shift = {dev, 1'b1};
      end
      TK_TXREG: begin
        r.step = ST_TXL; r.load = 1'b1; r.shift = reg_addr;
      end
      TK_TXREG2: begin
        r.step = ST_TXL; r.load = 1'b1; r.shift = reg_addr + 8'd1;
      end
      TK_TXDATA: begin
        r.step = ST_TXL; r.load = 1'b1; r.shift = wbyte;
      end
      TK_RSTART: r.step = ST_RSA;
      TK_RX, TK_RX2: begin
        r.step = ST_RXL; r.load = 1'b1;
      end
      default:   r.step = ST_PA;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/i2c_register_master.sv
`default_nettype none

// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+---------------------------
// in        | input     | in_valid_i / in_ready_o | in_item_i  (in_item_t)
// out       | output    | out_valid_o/ out_ready_i| out_item_o (out_item_t)
// cfg       | input     | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// Each item is one bus tick; it is turned into one registered result item, so one item
// per clock is sustained while results are taken. The result sits in one output register.
// in_ready_o is low only while that register holds an untaken result.
// Reset: idle, lines high and driven, address 104, 5 ticks per phase.
// Sequencer state advances only when an item is accepted.

module i2c_register_master
  import i2crm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o,
  input  wire logic      cfg_we_i,
  input  wire cfg_reg_e  cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  // configuration
  logic [6:0] dev_q;
  logic [7:0] tpp_q;

  // sequencer state
  step_e       step_q, step_a, step_d;
  stage_t      stage_q, stage_a, stage_d;
  logic [7:0]  phase_q, phase_a, phase_d;
  logic [3:0]  bit_q, bit_a, bit_d;
  logic [7:0]  shift_q, shift_a, shift_d;
  cmd_e        hcmd_q, hcmd_a;
  logic [7:0]  hreg_q, hreg_a;
  logic [7:0]  hwb_q, hwb_a;
  logic [15:0] word_q, word_d;
  logic        ack_q, ack_a, ack_d;

  logic        out_valid_q;
  out_item_t   out_q, res;

  logic        in_fire;
  logic        latch;
  tok_start_t  tb_first, tb_nx;
  stage_cnt_t  stage_inc;
  logic        fin;
  logic        phase_end;
  logic [7:0]  tpp_eff;
  logic [3:0]  bit_rev;
  logic        scl, sda, drv;
  logic        done;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // command latch: a command is taken only while idle
  assign latch    = (step_q == ST_IDLE) && (in_item_i.command != CMD_NONE);
  assign tb_first = tok_begin(cur_token(in_item_i.command, '0), dev_q,
                              in_item_i.register_address, in_item_i.write_data);

  always_comb begin
    step_a  = step_q;
    stage_a = stage_q;
    phase_a = phase_q;
    bit_a   = bit_q;
    shift_a = shift_q;
    hcmd_a  = hcmd_q;
    hreg_a  = hreg_q;
    hwb_a   = hwb_q;
    ack_a   = ack_q;
    if (latch) begin
      hcmd_a  = in_item_i.command;
      hreg_a  = in_item_i.register_address;
      hwb_a   = in_item_i.write_data;
      ack_a   = 1'b0;
      stage_a = '0;
      phase_a = '0;
      bit_a   = '0;
      step_a  = tb_first.step;
      if (tb_first.load) shift_a = tb_first.shift;
    end
  end

  // end of token: move on to the next program token or finish
  assign stage_inc = {1'b0, stage_a} + stage_cnt_t'(1);
  assign fin       = stage_inc >= prog_len(hcmd_a);
  assign tb_nx     = tok_begin(cur_token(hcmd_a, stage_inc[StageW-1:0]), dev_q,
                               hreg_a, hwb_a);

  assign tpp_eff   = (tpp_q == 8'd0) ? 8'd1 : tpp_q;
  assign phase_end = ({1'b0, phase_a} + 9'd1) >= {1'b0, tpp_eff};

  // next state
  always_comb begin
    logic end_tok;
    end_tok = 1'b0;
    step_d  = step_a;
    stage_d = stage_a;
    phase_d = phase_a;
    bit_d   = bit_a;
    shift_d = shift_a;
    word_d  = word_q;
    ack_d   = ack_a;
    if (step_a != ST_IDLE) begin
      if (phase_end) begin
        phase_d = '0;
        case (step_a)
          ST_TXL: step_d = ST_TXH;
          ST_TXH: begin
            if (bit_a >= 4'd8) begin
              if (in_item_i.sda_sample) ack_d = 1'b1;
              end_tok = 1'b1;
            end else begin
              bit_d  = bit_a + 4'd1;
              step_d = ST_TXL;
            end
          end
          ST_RSA: step_d = ST_RSB;
          ST_RSB: step_d = ST_RSC;
          ST_RXL: step_d = ST_RXH;
          ST_RXH: begin
            if (bit_a < 4'd8) begin
              shift_d = {shift_a[6:0], in_item_i.sda_sample};
              bit_d   = bit_a + 4'd1;
              step_d  = ST_RXL;
            end else begin
              if (cur_token(hcmd_a, stage_a) == TK_RX2)
                word_d = {word_q[7:0], shift_a};
              else
                word_d = {8'h00, shift_a};
              end_tok = 1'b1;
            end
          end
          ST_PA: step_d = ST_PB;
          ST_PB: step_d = ST_PC;
          default: end_tok = 1'b1;  // START, RSC, PC
        endcase
        if (end_tok) begin
          bit_d = '0;
          if (fin) begin
            step_d  = ST_IDLE;
            stage_d = '0;
          end else begin
            stage_d = stage_inc[StageW-1:0];
            step_d  = tb_nx.step;
            if (tb_nx.load) shift_d = tb_nx.shift;
          end
        end
      end else begin
        phase_d = phase_a + 8'd1;
      end
    end
    done = end_tok && fin;
  end

  // line levels for this tick, from the step after any command latch
  assign bit_rev = 4'd7 - bit_a;

  always_comb begin
    scl = 1'b1;
    sda = 1'b1;
    drv = 1'b1;
    case (step_a)
      ST_START: sda = 1'b0;
      ST_TXL, ST_TXH: begin
        scl = (step_a == ST_TXH);
        if (bit_a < 4'd8) begin
          sda = shift_a[bit_rev[2:0]];
        end else begin
          drv = 1'b0;  // slave ACK slot
        end
      end
      ST_RSA: scl = 1'b0;
      ST_RSB: ;
      ST_RSC: sda = 1'b0;
      ST_RXL, ST_RXH: begin
        scl = (step_a == ST_RXH);
        drv = (bit_a >= 4'd8);  // master NACK after the data bits
      end
      ST_PA: begin
        scl = 1'b0; sda = 1'b0;
      end
      ST_PB: sda = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    res.scl_level = scl;
    res.sda_level = sda;
    res.sda_drive = drv;
    res.busy_res  = (step_a != ST_IDLE);
    res.done_res  = done;
    res.read_data = word_d;
    res.nack_seen = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q       <= DEV_ADDR_RESET;
      tpp_q       <= TPP_RESET;
      step_q      <= ST_IDLE;
      stage_q     <= '0;
      phase_q     <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      hcmd_q      <= CMD_NONE;
      hreg_q      <= '0;
      hwb_q       <= '0;
      word_q      <= '0;
      ack_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEVICE_ADDRESS:  dev_q <= cfg_data_i[6:0];
          CFG_TICKS_PER_PHASE: tpp_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        step_q  <= step_d;
        stage_q <= stage_d;
        phase_q <= phase_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        hcmd_q  <= hcmd_a;
        hreg_q  <= hreg_a;
        hwb_q   <= hwb_a;
        word_q  <= word_d;
        ack_q   <= ack_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) out_q <= res;
  end

  // a stalled result freezes the sequencer
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(step_q) && $stable(phase_q))
    else $error("sequencer moved while result stalled");

  a_busy_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != ST_IDLE |-> hcmd_q != CMD_NONE)
    else $error("busy without a held command");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd8)
    else $error("bit counter out of range");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> out_q.busy_res && step_q == ST_IDLE)
    else $error("done without finishing the transaction");

  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.busy_res |-> out_q.scl_level && out_q.sda_level
                                       && out_q.sda_drive)
    else $error("idle lines not released high");

endmodule

`default_nettype wire

FILE: bench/i2c_register_master_test.sv
module i2c_register_master_test;
  import i2crm_pkg::*;

  // Random ticks after the directed plan
  localparam int RANDOM_TICKS = 1530;
  // Cycles allowed for stray outputs once nothing is pending
  localparam int DRAIN_CYCLES = 8;
  // Hard stop, in time units (well above the slowest legal run)
  localparam int RUN_LIMIT    = 2_000_000;
  // Mismatch lines printed before going quiet
  localparam int REPORT_CAP   = 100;
  localparam int PLAN_ROWS    = 17;

  // Outputs that can be read straight off the protocol
  localparam out_item_t IDLE_OUT  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0};
  localparam out_item_t START_OUT = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0};
  localparam out_item_t NO_OUT    = '0;
  localparam in_item_t  NO_TICK   = '{CMD_NONE, 8'h00, 8'h00, 1'b0};

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  in_item_t   in_item_i   = '0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_we_i    = 1'b0;
  cfg_reg_e   cfg_index_i = CFG_DEVICE_ADDRESS;
  logic [7:0] cfg_data_i  = '0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  i2c_register_master u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Bus sequencer predictor: one call per accepted tick
  // ---------------------------------------------------------------------------
  logic [6:0]  dev_addr   = DEV_ADDR_RESET;
  logic [7:0]  phase_len  = TPP_RESET;

  step_e       seq_step   = ST_IDLE;
  int          stage_idx  = 0;      // position in the transaction program
  logic [7:0]  phase_cnt  = '0;     // ticks spent in the current line phase
  logic [3:0]  bit_idx    = '0;     // 0..7 data bits, 8 = ack slot
  logic [7:0]  shreg      = '0;
  cmd_e        held_cmd   = CMD_NONE;
  logic [7:0]  held_reg   = '0;
  logic [7:0]  held_wbyte = '0;
  logic [15:0] read_word  = '0;
  logic        nack_flag  = 1'b0;
  logic [2:0]  line_bits  = 3'b111; // {scl, sda, drive}

  function automatic int program_len(cmd_e c);
    case (c)
      CMD_WRITE_BYTE: return 5;
      CMD_READ_BYTE:  return 7;
      CMD_READ_WORD:  return 14;
      default:        return 0;
    endcase
  endfunction

  // Word read is two byte reads back to back; the second targets reg+1
  function automatic token_e program_token(cmd_e c, int s);
    if (s >= program_len(c)) return TK_STOP;
    if (c == CMD_WRITE_BYTE) begin
      case (s)
        0:       return TK_START;
        1:       return TK_TXW;
        2:       return TK_TXREG;
        3:       return TK_TXDATA;
        default: return TK_STOP;
      endcase
    end
    case (s % 7)
      0:       return TK_START;
      1:       return TK_TXW;
      2:       return (s < 7) ? TK_TXREG : TK_TXREG2;
      3:       return TK_RSTART;
      4:       return TK_TXR;
      5:       return (s < 7) ? TK_RX : TK_RX2;
      default: return TK_STOP;
    endcase
  endfunction

  // Address is sampled here, so a mid-transaction address write lands on the next address byte
  function automatic void open_token();
    bit_idx = '0;
    case (program_token(held_cmd, stage_idx))
      TK_START:  seq_step = ST_START;
      TK_TXW: begin
        shreg = {dev_addr, 1'b0}; seq_step = ST_TXL;
      end
      TK_TXR: begin
        shreg = {dev_addr, 1'b1}; seq_step = ST_TXL;
      end
      TK_TXREG: begin
        shreg = held_reg; seq_step = ST_TXL;
      end
      TK_TXREG2: begin
        shreg = held_reg + 8'd1; seq_step = ST_TXL;
      end
      TK_TXDATA: begin
        shreg = held_wbyte; seq_step = ST_TXL;
      end
      TK_RSTART: seq_step = ST_RSA;
      TK_RX, TK_RX2: begin
        shreg = '0; seq_step = ST_RXL;
      end
      default:   seq_step = ST_PA;
    endcase
  endfunction

  // Returns 1 when the last token of the transaction has finished
  function automatic bit close_token();
    stage_idx++;
    if (stage_idx >= program_len(held_cmd)) begin
      seq_step  = ST_IDLE;
      stage_idx = 0;
      bit_idx   = '0;
      return 1'b1;
    end
    open_token();
    return 1'b0;
  endfunction

  function automatic logic [2:0] step_lines();
    logic scl, sda, drv;
    scl = 1'b1; sda = 1'b1; drv = 1'b1;
    case (seq_step)
      ST_START: sda = 1'b0;
      ST_TXL, ST_TXH: begin
        scl = (seq_step == ST_TXH);
        if (bit_idx < 4'd8) sda = shreg[3'd7 - bit_idx[2:0]];
        else drv = 1'b0;           // released for the slave ack
      end
      ST_RSA:   scl = 1'b0;
      ST_RSC:   sda = 1'b0;
      ST_RXL, ST_RXH: begin
        scl = (seq_step == ST_RXH);
        drv = (bit_idx >= 4'd8);   // master NACK after eight bits in
      end
      ST_PA: begin
        scl = 1'b0; sda = 1'b0;
      end
      ST_PB:    sda = 1'b0;
      default: ;
    endcase
    return {scl, sda, drv};
  endfunction

  function automatic out_item_t sequence_tick(in_item_t it);
    out_item_t  o;
    logic [7:0] span;
    logic       done;
    o    = '0;
    done = 1'b0;
    span = (phase_len == 8'd0) ? 8'd1 : phase_len;   // zero behaves as one tick
    // Commands are taken only when idle; the sequence starts on this tick
    if (seq_step == ST_IDLE && it.command != CMD_NONE) begin
      held_cmd   = it.command;
      held_reg   = it.register_address;
      held_wbyte = it.write_data;
      nack_flag  = 1'b0;
      stage_idx  = 0;
      phase_cnt  = '0;
      open_token();
    end
    if (seq_step == ST_IDLE) begin
      line_bits = 3'b111;
    end else begin
      o.busy_res = 1'b1;
      line_bits  = step_lines();
      if ({1'b0, phase_cnt} + 9'd1 >= {1'b0, span}) begin
        phase_cnt = '0;
        case (seq_step)
          ST_TXL: seq_step = ST_TXH;
          ST_TXH: begin
            if (bit_idx >= 4'd8) begin
              if (it.sda_sample) nack_flag = 1'b1;   // reported, never aborts
              done = close_token();
            end else begin
              bit_idx++;
              seq_step = ST_TXL;
            end
          end
          ST_RSA: seq_step = ST_RSB;
          ST_RSB: seq_step = ST_RSC;
          ST_RXL: seq_step = ST_RXH;
          ST_RXH: begin
            if (bit_idx < 4'd8) begin
              shreg = {shreg[6:0], it.sda_sample};
              bit_idx++;
              seq_step = ST_RXL;
            end else begin
              // second byte of a word read shifts the first into the high half
              if (program_token(held_cmd, stage_idx) == TK_RX2)
                read_word = {read_word[7:0], shreg};
              else
                read_word = {8'h00, shreg};
              done = close_token();
            end
          end
          ST_PA:  seq_step = ST_PB;
          ST_PB:  seq_step = ST_PC;
          default: done = close_token();    // START, repeated START end, STOP end
        endcase
      end else begin
        phase_cnt = phase_cnt + 8'd1;
      end
    end
    o.scl_level = line_bits[2];
    o.sda_level = line_bits[1];
    o.sda_drive = line_bits[0];
    o.done_res  = done;
    o.read_data = read_word;
    o.nack_seen = nack_flag;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall pattern and field-by-field compare
  // ---------------------------------------------------------------------------
  out_item_t pending_outputs[$];
  int        mismatch_count = 0;
  int        ready_clk      = 0;

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) $display("mismatch @%0t: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("output item with nothing pending");
      end else begin
        want = pending_outputs.pop_front();
        if (out_item_o.scl_level !== want.scl_level)
          report_mismatch($sformatf("scl_level %b want %b", out_item_o.scl_level,
                                    want.scl_level));
        if (out_item_o.sda_level !== want.sda_level)
          report_mismatch($sformatf("sda_level %b want %b", out_item_o.sda_level,
                                    want.sda_level));
        if (out_item_o.sda_drive !== want.sda_drive)
          report_mismatch($sformatf("sda_drive %b want %b", out_item_o.sda_drive,
                                    want.sda_drive));
        if (out_item_o.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b want %b", out_item_o.busy_res,
                                    want.busy_res));
        if (out_item_o.done_res !== want.done_res)
          report_mismatch($sformatf("done_res %b want %b", out_item_o.done_res,
                                    want.done_res));
        if (out_item_o.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h want %h", out_item_o.read_data,
                                    want.read_data));
        if (out_item_o.nack_seen !== want.nack_seen)
          report_mismatch($sformatf("nack_seen %b want %b", out_item_o.nack_seen,
                                    want.nack_seen));
      end
    end
    // Four rotating stall modes: none, random, short periodic, long periodic
    ready_clk++;
    case ((ready_clk / 200) % 4)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 2) != 0);
      2:       out_ready_i <= ((ready_clk % 5) >= 2);
      default: out_ready_i <= ((ready_clk % 16) >= 7);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // Bursts of back-to-back ticks separated by random gaps; valid is only
  // dropped when a real gap follows
  task automatic push_tick(in_item_t it, logic typed, out_item_t want);
    int        gap;
    out_item_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 300)
                                                : $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = sequence_tick(it);
    pending_outputs.push_back(typed ? want : predicted);
    burst_left--;
  endtask

  // Stop sending and wait until every pending output has been taken
  task automatic settle();
    in_valid_i <= 1'b0;
    wait (pending_outputs.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e sel, logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_DEVICE_ADDRESS) dev_addr = value[6:0];
    else phase_len = value;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan: expected outputs typed in where obvious, else predicted
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic       is_cfg;
    cfg_reg_e   cfg_sel;
    logic [7:0] cfg_value;
    in_item_t   tick;
    logic       typed;
    out_item_t  want;
  } plan_row_t;

  plan_row_t plan [PLAN_ROWS] = '{
    // idle lines after reset, field extremes with no command
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, NO_TICK,                            1'b1, IDLE_OUT},
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, '{CMD_NONE, 8'hFF, 8'hFF, 1'b1},    1'b1, IDLE_OUT},
    // top address, zero ticks per phase (runs as one)
    '{1'b1, CFG_DEVICE_ADDRESS,  8'h7F, NO_TICK,                            1'b0, NO_OUT},
    '{1'b1, CFG_TICKS_PER_PHASE, 8'h00, NO_TICK,                            1'b0, NO_OUT},
    // write taken on the same tick: START lines straight away
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, '{CMD_WRITE_BYTE, 8'h00, 8'hFF, 1'b0},
      1'b1, START_OUT},
    // commands while busy are dropped
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, '{CMD_READ_WORD, 8'hFF, 8'h00, 1'b1}, 1'b0, NO_OUT},
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, '{CMD_READ_BYTE, 8'h80, 8'h55, 1'b1}, 1'b0, NO_OUT},
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, NO_TICK,                            1'b0, NO_OUT},
    // phase length changed mid-transaction, largest value
    '{1'b1, CFG_TICKS_PER_PHASE, 8'hFF, NO_TICK,                            1'b0, NO_OUT},
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, '{CMD_NONE, 8'h00, 8'h00, 1'b1},    1'b0, NO_OUT},
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, '{CMD_WRITE_BYTE, 8'hFF, 8'h00, 1'b0}, 1'b0, NO_OUT},
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, NO_TICK,                            1'b0, NO_OUT},
    // address changed mid-transaction, back to one tick per phase
    '{1'b1, CFG_DEVICE_ADDRESS,  8'h00, NO_TICK,                            1'b0, NO_OUT},
    '{1'b1, CFG_TICKS_PER_PHASE, 8'h01, NO_TICK,                            1'b0, NO_OUT},
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, '{CMD_NONE, 8'hFF, 8'hFF, 1'b1},    1'b0, NO_OUT},
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, '{CMD_READ_WORD, 8'h00, 8'hFF, 1'b0}, 1'b0, NO_OUT},
    '{1'b0, CFG_DEVICE_ADDRESS,  8'h00, NO_TICK,                            1'b0, NO_OUT}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t   tick;
    logic [7:0] dev_pick;
    logic [7:0] tpp_pick;
    int         sent;
    int         phase_ticks;
    logic       ack_slot;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].is_cfg) begin
        settle();
        write_cfg(plan[r].cfg_sel, plan[r].cfg_value);
      end else begin
        push_tick(plan[r].tick, plan[r].typed, plan[r].want);
      end
    end

    // Random phases. Each phase starts from a drained pipeline, so the
    // sender fully pauses here; the sequencer itself may be mid-transaction.
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      settle();
      case ($urandom_range(0, 3))
        0:       dev_pick = 8'h00;
        1:       dev_pick = 8'h7F;
        default: dev_pick = 8'($urandom_range(0, 127));
      endcase
      // mostly short phases so transactions run to the end
      case ($urandom_range(0, 15))
        0:       tpp_pick = 8'h00;
        1:       tpp_pick = 8'hFF;
        2, 3:    tpp_pick = 8'($urandom_range(4, 12));
        default: tpp_pick = 8'($urandom_range(1, 3));
      endcase
      write_cfg(CFG_DEVICE_ADDRESS, dev_pick);
      write_cfg(CFG_TICKS_PER_PHASE, tpp_pick);
      phase_ticks = (tpp_pick == 8'hFF) ? $urandom_range(40, 80) : $urandom_range(60, 200);

      for (int k = 0; k < phase_ticks; k++) begin
        // idle: start a new transaction most of the time
        if (seq_step == ST_IDLE)
          tick.command = ($urandom_range(0, 9) < 8) ? cmd_e'($urandom_range(1, 3)) : CMD_NONE;
        else
          tick.command = cmd_e'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
          0:       tick.register_address = 8'hFF;   // reg+1 wraps on word reads
          1:       tick.register_address = 8'h00;
          default: tick.register_address = 8'($urandom_range(0, 255));
        endcase
        tick.write_data = 8'($urandom_range(0, 255));
        // slaves mostly ack; data bits are random
        ack_slot = (seq_step == ST_TXH) && (bit_idx == 4'd8);
        tick.sda_sample = ack_slot ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
        push_tick(tick, 1'b0, NO_OUT);
        sent++;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS i2c_register_master");
    end else begin
      $display("FAIL i2c_register_master");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAIL i2c_register_master");
    $finish;
  end

endmodule
